// File: design/rowf_pkg.sv
// rowf_pkg: shared types and constants of the range outlier window filter
// no dependencies; imported by range_outlier_window_filter_core
package rowf_pkg;

  localparam int unsigned DIST_W   = 16;
  localparam int unsigned STAT_W   = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MIN_FILL = 3;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WMEAN  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RAW    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATCK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATECK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd5;

  // reset values
  localparam logic [MODE_W-1:0] RST_MODE   = MODE_MEDIAN;
  localparam logic [LEN_W-1:0]  RST_LENGTH = 4'd5;
  localparam logic [DIST_W-1:0] RST_JUMP   = 16'd500;
  localparam logic [MASK_W-1:0] RST_MASK   = 32'h0000_0001;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED_LOAD,
    ST_MED_CMP,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } rowf_state_e;

endpackage

// File: design/range_outlier_window_filter_core.sv
// range_outlier_window_filter_core: screening, circular window and iterative filter
// depends on rowf_pkg
//
// Each item is taken only while the sequencer is idle. A clear item, a rejected
// sample, a sample that leaves fewer than three entries held, or raw mode goes
// from idle straight to done. Mean and recency-weighted mean walk the window once
// through a single multiply-accumulate and then run a restoring divider, one
// quotient bit per cycle. Median ranks each entry against every entry, itself
// included, through one comparator pair. The next item can be taken while a
// finished result still waits at the output.
module range_outlier_window_filter_core
  import rowf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MASK_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // sample_mm [15:0], sensor_status [23:16]
  input  logic                 s_axis_tuser,   // opcode
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // filtered_mm [15:0]
  output logic                 m_axis_tuser    // accepted
);

  localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TOT_MAX = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
  localparam int unsigned TOT_W  = $clog2(TOT_MAX + 1);
  localparam int unsigned SUM_W  = DIST_W + TOT_W;
  localparam int unsigned PROD_W = DIST_W + CNT_W;
  localparam int unsigned DC_W   = $clog2(SUM_W + 1);

  // configuration registers
  logic [MODE_W-1:0] filter_mode_q;
  logic [LEN_W-1:0]  window_length_q;
  logic              status_check_on_q;
  logic              rate_check_on_q;
  logic [DIST_W-1:0] max_jump_mm_q;
  logic [MASK_W-1:0] valid_status_bits_q;

  // history
  logic [DIST_W-1:0] win_q [MAX_WINDOW];
  logic [IDX_W-1:0]  wi_q, wi_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [DIST_W-1:0] last_q;

  // sequencer
  rowf_state_e       state_q, state_d;
  logic [IDX_W-1:0]  i_q, j_q, idx_q, idx0;
  logic [CNT_W-1:0]  w_q;
  logic [CNT_W-1:0]  lt_q, le_q, lt_n, le_n;
  logic [DC_W-1:0]   dcnt_q;
  logic [DIST_W-1:0] cand_q, med_lo_q, med_hi_q, med_lo_n, med_hi_n;
  logic [SUM_W-1:0]  acc_q, acc_n, num_q, num_n;
  logic [TOT_W-1:0]  tot_q, tot_n;
  logic [TOT_W:0]    rem_q, rem_sh, rem_n;
  logic [DIST_W-1:0] res_q;
  logic              res_acc_q;

  // output register
  logic              out_valid_q;
  logic              out_acc_q;
  logic [DIST_W-1:0] out_mm_q;

  // item fields
  logic              in_op;
  logic [DIST_W-1:0] in_dist;
  logic [STAT_W-1:0] in_stat;

  logic [CNT_W-1:0]  n_eff;
  logic              fire, status_ok, rate_ok, take;
  logic [DIST_W-1:0] diff;
  logic [IDX_W-1:0]  rd_addr;
  logic [DIST_W-1:0] rd_val;
  logic [CNT_W-1:0]  wsel, k_rank;
  logic [PROD_W-1:0] prod;
  logic              j_last, i_last, hi_hit, lo_hit, q_bit;
  logic [DIST_W:0]   mid_sum;
  logic              fin_en, fin_acc, out_load;
  logic [DIST_W-1:0] fin_val;

  assign in_op   = s_axis_tuser;
  assign in_dist = s_axis_tdata[15:0];
  assign in_stat = s_axis_tdata[23:16];

  // effective window length, clamped to [3, MAX_WINDOW]
  always_comb begin
    if (32'(window_length_q) < MIN_FILL) begin
      n_eff = CNT_W'(MIN_FILL);
    end else if (32'(window_length_q) > MAX_WINDOW) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(window_length_q);
    end
  end

  // screening
  assign diff      = (in_dist >= last_q) ? in_dist - last_q : last_q - in_dist;
  assign status_ok = !status_check_on_q ||
                     ((in_stat[7:5] == 3'd0) && valid_status_bits_q[in_stat[4:0]]);
  assign rate_ok   = !rate_check_on_q || (fill_q == '0) || (diff <= max_jump_mm_q);
  assign take      = (in_op == OP_SAMPLE) && status_ok && rate_ok;
  assign fire      = s_axis_tvalid && s_axis_tready;

  // window update for an accepted sample
  assign wi_d   = (CNT_W'(wi_q) + CNT_W'(1) == n_eff) ? '0 : wi_q + IDX_W'(1);
  assign fill_d = (fill_q < n_eff) ? fill_q + CNT_W'(1) : fill_q;
  assign idx0   = (wi_d == '0) ? IDX_W'(fill_d - CNT_W'(1)) : wi_d - IDX_W'(1);

  // single read port of the window
  always_comb begin
    case (state_q)
      ST_MED_LOAD: rd_addr = i_q;
      ST_MED_CMP:  rd_addr = j_q;
      default:     rd_addr = idx_q;
    endcase
  end
  assign rd_val = win_q[rd_addr];

  // rank counting for median, a candidate is placed only once its counts are complete
  assign lt_n    = lt_q + CNT_W'(rd_val < cand_q);
  assign le_n    = le_q + CNT_W'(rd_val <= cand_q);
  assign k_rank  = fill_q >> 1;
  assign j_last  = (CNT_W'(j_q) == fill_q - CNT_W'(1));
  assign i_last  = (CNT_W'(i_q) == fill_q - CNT_W'(1));
  assign hi_hit  = j_last && (lt_n <= k_rank) && (le_n > k_rank);
  assign lo_hit  = j_last && (lt_n < k_rank) && (le_n >= k_rank);
  assign med_hi_n = hi_hit ? cand_q : med_hi_q;
  assign med_lo_n = lo_hit ? cand_q : med_lo_q;
  assign mid_sum  = {1'b0, med_lo_n} + {1'b0, med_hi_n};

  // shared multiply-accumulate: recency weight for weighted mean, weight 1 otherwise
  assign wsel  = (filter_mode_q == MODE_WMEAN) ? w_q : CNT_W'(1);
  assign prod  = PROD_W'(rd_val) * PROD_W'(wsel);
  assign acc_n = acc_q + SUM_W'(prod);
  assign tot_n = tot_q + TOT_W'(wsel);

  // restoring divider step
  assign rem_sh = {rem_q[TOT_W-1:0], num_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, tot_q});
  assign rem_n  = q_bit ? rem_sh - {1'b0, tot_q} : rem_sh;
  assign num_n  = {num_q[SUM_W-2:0], q_bit};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          if (!take || (32'(fill_d) < MIN_FILL) || (filter_mode_q == MODE_RAW)) begin
            state_d = ST_DONE;
          end else if (filter_mode_q == MODE_MEDIAN) begin
            state_d = ST_MED_LOAD;
          end else begin
            state_d = ST_SUM;
          end
        end
      end
      ST_MED_LOAD: state_d = ST_MED_CMP;
      ST_MED_CMP: begin
        if (j_last) begin
          state_d = i_last ? ST_DONE : ST_MED_LOAD;
        end
      end
      ST_SUM: begin
        if (w_q == CNT_W'(1)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_q == DC_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    fin_en        = 1'b0;
    fin_acc       = 1'b0;
    fin_val       = '0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (fire && (!take || (32'(fill_d) < MIN_FILL) || (filter_mode_q == MODE_RAW))) begin
          fin_en  = 1'b1;
          fin_acc = take;
          fin_val = take ? in_dist : '0;
        end
      end
      ST_MED_CMP: begin
        if (j_last && i_last) begin
          fin_en  = 1'b1;
          fin_acc = 1'b1;
          fin_val = fill_q[0] ? med_hi_n : mid_sum[DIST_W:1];
        end
      end
      ST_DIV: begin
        if (dcnt_q == DC_W'(1)) begin
          fin_en  = 1'b1;
          fin_acc = 1'b1;
          fin_val = num_n[DIST_W-1:0];
        end
      end
      ST_DONE: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_IDLE;
      filter_mode_q       <= RST_MODE;
      window_length_q     <= RST_LENGTH;
      status_check_on_q   <= 1'b1;
      rate_check_on_q     <= 1'b1;
      max_jump_mm_q       <= RST_JUMP;
      valid_status_bits_q <= RST_MASK;
      wi_q                <= '0;
      fill_q              <= '0;
      last_q              <= '0;
      i_q                 <= '0;
      j_q                 <= '0;
      idx_q               <= '0;
      w_q                 <= '0;
      lt_q                <= '0;
      le_q                <= '0;
      dcnt_q              <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (fire && (in_op == OP_CLEAR)) begin
            wi_q   <= '0;
            fill_q <= '0;
            last_q <= '0;
          end else if (fire && take) begin
            wi_q   <= wi_d;
            fill_q <= fill_d;
          end
          i_q   <= '0;
          idx_q <= idx0;
          w_q   <= fill_d;
        end
        ST_MED_LOAD: begin
          j_q  <= '0;
          lt_q <= '0;
          le_q <= '0;
        end
        ST_MED_CMP: begin
          j_q  <= j_q + IDX_W'(1);
          lt_q <= lt_n;
          le_q <= le_n;
          if (j_last) begin
            i_q <= i_q + IDX_W'(1);
          end
        end
        ST_SUM: begin
          w_q    <= w_q - CNT_W'(1);
          idx_q  <= (idx_q == '0) ? IDX_W'(fill_q - CNT_W'(1)) : idx_q - IDX_W'(1);
          dcnt_q <= DC_W'(SUM_W);
        end
        ST_DIV: dcnt_q <= dcnt_q - DC_W'(1);
        default: ;
      endcase
      if (fin_en && fin_acc) begin
        last_q <= fin_val;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:   filter_mode_q <= cfg_wdata_i[MODE_W-1:0];
          REG_LENGTH: begin
            window_length_q <= cfg_wdata_i[LEN_W-1:0];
            wi_q            <= '0;
            fill_q          <= '0;
          end
          REG_STATCK: status_check_on_q   <= cfg_wdata_i[0];
          REG_RATECK: rate_check_on_q     <= cfg_wdata_i[0];
          REG_JUMP:   max_jump_mm_q       <= cfg_wdata_i[DIST_W-1:0];
          REG_MASK:   valid_status_bits_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (fire && take) begin
          win_q[wi_q] <= in_dist;
        end
        acc_q <= '0;
        tot_q <= '0;
      end
      ST_MED_LOAD: cand_q <= rd_val;
      ST_MED_CMP: begin
        med_hi_q <= med_hi_n;
        med_lo_q <= med_lo_n;
      end
      ST_SUM: begin
        acc_q <= acc_n;
        tot_q <= tot_n;
        if (w_q == CNT_W'(1)) begin
          num_q <= acc_n;
          rem_q <= '0;
        end
      end
      ST_DIV: begin
        num_q <= num_n;
        rem_q <= rem_n;
      end
      default: ;
    endcase
    if (fin_en) begin
      res_q     <= fin_val;
      res_acc_q <= fin_acc;
    end
    if (out_load) begin
      out_mm_q  <= res_q;
      out_acc_q <= res_acc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mm_q;
  assign m_axis_tuser  = out_acc_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= n_eff)
    else $error("fill count beyond window length");

  a_wi_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(wi_q) < n_eff)
    else $error("write index beyond window length");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result shown without finished item");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("rejected item carries nonzero distance");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (tot_q != '0))
    else $error("divider started with zero weight total");

endmodule
